@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define STA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies consequence in the next cycle
`define STA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/sta_pkg.sv @@
package sta_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int SPEED_W   = 32;
  localparam int TSTEP_W   = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b1;

  localparam logic signed [SPEED_W-1:0] SPEED_RST = 32'sd65536;
  localparam logic [TSTEP_W-1:0]        TSTEP_RST = 31'd655;

  // q1.30 ratios and the final shift after dropping 32 low product bits
  localparam int Q_FRAC  = 30;
  localparam int QUO_W   = Q_FRAC + 1;
  localparam int SH      = FRAC_BITS + Q_FRAC - 32;
  localparam int DISP_W  = 64 - SH;
  localparam int FIN_W   = DISP_W + 2;
  localparam int SQ_N    = 32;
  localparam int DIV_N   = QUO_W;
  localparam int LANES   = 4;

  // pipeline depth: capture, square, sum, root steps, prep, divide steps,
  // multiply, round, displacement multiply, displacement sum, output
  localparam int NST = 3 + SQ_N + 1 + DIV_N + 5;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } root_t;

  typedef struct packed {
    logic [63:0] rem_a;
    logic [63:0] res_a;
    logic [63:0] rem_b;
    logic [63:0] res_b;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } sq_t;

  typedef struct packed {
    logic [LANES-1:0][63:0]      rem;
    logic [LANES-1:0][31:0]      den;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic signed [COORD_W-1:0]   z;
    logic                        deg;
  } div_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic                      degenerate;
    logic                      saturated;
  } out_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? 32'(-v) : 32'(v);
    return m;
  endfunction

  function automatic root_t root_step(logic [63:0] rem, logic [63:0] res, logic [63:0] bit_v);
    logic [64:0] trial;
    root_t o;
    trial = {1'b0, res} + {1'b0, bit_v};
    if ({1'b0, rem} >= trial) begin
      o.rem = rem - trial[63:0];
      o.res = (res >> 1) + bit_v;
    end else begin
      o.rem = rem;
      o.res = res >> 1;
    end
    return o;
  endfunction

endpackage

@@ rtl/sta_if.sv @@
interface sta_in_if;
  logic valid;
  logic ready;
  logic signed [sta_pkg::COORD_W-1:0] pos_x;
  logic signed [sta_pkg::COORD_W-1:0] pos_y;
  logic signed [sta_pkg::COORD_W-1:0] pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface sta_out_if;
  logic valid;
  logic ready;
  logic signed [sta_pkg::COORD_W-1:0] new_x;
  logic signed [sta_pkg::COORD_W-1:0] new_y;
  logic signed [sta_pkg::COORD_W-1:0] new_z;
  logic degenerate;
  logic saturated;
  modport source (output valid, output new_x, output new_y, output new_z,
                  output degenerate, output saturated, input ready);
  modport sink (input valid, input new_x, input new_y, input new_z,
                input degenerate, input saturated, output ready);
endinterface

@@ rtl/spherical_tangent_advect.sv @@
// channel   dir  payload                                   beat when
// in_ch     in   pos_x, pos_y, pos_z                       valid && ready
// out_ch    out  new_x, new_y, new_z, degenerate, saturated valid && ready
// cfg       in   cfg_idx, cfg_data                         cfg_we
//
// one vertex per cycle while no result waits at the output
// 32 square root steps and 31 divide steps, one per stage
// synchronous active-low reset clears stage valid bits and loads speed and time step reset values
// the whole pipe holds while a result waits at the output, nothing is dropped
`include "assert_macros.svh"

module spherical_tangent_advect (
  input  logic clk,
  input  logic rst_n,
  sta_in_if.sink    in_ch,
  sta_out_if.source out_ch,
  input  logic                                cfg_we,
  input  logic [sta_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [sta_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SQ_N  = sta_pkg::SQ_N;
  localparam int DIV_N = sta_pkg::DIV_N;
  localparam int NST   = sta_pkg::NST;
  localparam int SH    = sta_pkg::SH;
  localparam int DW    = sta_pkg::DISP_W;
  localparam int FW    = sta_pkg::FIN_W;
  localparam int QW    = sta_pkg::QUO_W;
  localparam int QF    = sta_pkg::Q_FRAC;

  logic signed [sta_pkg::SPEED_W-1:0] speed_r;
  logic [sta_pkg::TSTEP_W-1:0]        time_step_r;
  logic [62:0]                        dmag_r;
  logic                               dneg_r;
  logic [31:0]                        speed_mag;

  logic [NST-1:0] vld_r;
  logic           adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= sta_pkg::SPEED_RST;
      time_step_r <= sta_pkg::TSTEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sta_pkg::CFG_SPEED:     speed_r     <= cfg_data;
        sta_pkg::CFG_TIME_STEP: time_step_r <= cfg_data[sta_pkg::TSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign speed_mag = sta_pkg::mag32(speed_r);

  always_ff @(posedge clk) begin
    dmag_r <= 63'(time_step_r) * 63'(speed_mag);
    dneg_r <= speed_r[31];
  end

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // capture and squares
  logic signed [31:0] x1_r, y1_r, z1_r;
  logic signed [31:0] x2_r, y2_r, z2_r;
  logic [63:0]        sqx_r, sqy_r, sqz_r;
  logic [31:0]        mx1, my1, mz1;

  assign mx1 = sta_pkg::mag32(x1_r);
  assign my1 = sta_pkg::mag32(y1_r);
  assign mz1 = sta_pkg::mag32(z1_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= in_ch.pos_x;
      y1_r  <= in_ch.pos_y;
      z1_r  <= in_ch.pos_z;
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      z2_r  <= z1_r;
      sqx_r <= 64'(mx1) * 64'(mx1);
      sqy_r <= 64'(my1) * 64'(my1);
      sqz_r <= 64'(mz1) * 64'(mz1);
    end
  end

  // square roots of rho^2 and r^2
  sta_pkg::sq_t sq_r [SQ_N+1];
  logic [63:0]  rho2;

  assign rho2 = sqx_r + sqy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].rem_a <= rho2;
      sq_r[0].res_a <= '0;
      sq_r[0].rem_b <= rho2 + sqz_r;
      sq_r[0].res_b <= '0;
      sq_r[0].x     <= x2_r;
      sq_r[0].y     <= y2_r;
      sq_r[0].z     <= z2_r;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam logic [63:0] BitV = 64'(1) << (62 - 2 * j);
    sta_pkg::root_t ra, rb;
    assign ra = sta_pkg::root_step(sq_r[j].rem_a, sq_r[j].res_a, BitV);
    assign rb = sta_pkg::root_step(sq_r[j].rem_b, sq_r[j].res_b, BitV);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[j+1].rem_a <= ra.rem;
        sq_r[j+1].res_a <= ra.res;
        sq_r[j+1].rem_b <= rb.rem;
        sq_r[j+1].res_b <= rb.res;
        sq_r[j+1].x     <= sq_r[j].x;
        sq_r[j+1].y     <= sq_r[j].y;
        sq_r[j+1].z     <= sq_r[j].z;
      end
    end
  end

  // ratio setup: x/rho, y/rho, z/r, rho/r
  sta_pkg::div_t dv_r [DIV_N+1];
  logic [31:0]   rho_w, r_w;
  logic [3:0][31:0] num_w, den_w;

  assign rho_w = sq_r[SQ_N].res_a[31:0];
  assign r_w   = sq_r[SQ_N].res_b[31:0];
  assign num_w = {rho_w, sta_pkg::mag32(sq_r[SQ_N].z),
                  sta_pkg::mag32(sq_r[SQ_N].y), sta_pkg::mag32(sq_r[SQ_N].x)};
  assign den_w = {r_w, r_w, rho_w, rho_w};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < sta_pkg::LANES; l++) begin
        dv_r[0].rem[l] <= (64'(num_w[l]) << QF) + 64'(den_w[l] >> 1);
        dv_r[0].den[l] <= den_w[l];
        dv_r[0].quo[l] <= '0;
      end
      dv_r[0].x   <= sq_r[SQ_N].x;
      dv_r[0].y   <= sq_r[SQ_N].y;
      dv_r[0].z   <= sq_r[SQ_N].z;
      dv_r[0].deg <= (sq_r[SQ_N].x == '0) && (sq_r[SQ_N].y == '0);
    end
  end

  for (genvar t = 0; t < DIV_N; t++) begin : g_div
    localparam int K = DIV_N - 1 - t;
    sta_pkg::div_t dv_nxt;
    always_comb begin : c_step
      logic [63:0] shv;
      dv_nxt = dv_r[t];
      for (int l = 0; l < sta_pkg::LANES; l++) begin
        shv = 64'(dv_r[t].den[l]) << K;
        if (dv_r[t].rem[l] >= shv) begin
          dv_nxt.rem[l]    = dv_r[t].rem[l] - shv;
          dv_nxt.quo[l][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[t+1] <= dv_nxt;
      end
    end
  end

  // cos_a*cos_p and sin_a*cos_p
  logic [2*QW-1:0]    pcx_r, pcy_r;
  logic [QW-1:0]      sinp_r;
  logic               sx_r, sy_r, sz_r, deg_m_r;
  logic signed [31:0] xm_r, ym_r, zm_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pcx_r   <= (2*QW)'(dv_r[DIV_N].quo[0]) * (2*QW)'(dv_r[DIV_N].quo[2]);
      pcy_r   <= (2*QW)'(dv_r[DIV_N].quo[1]) * (2*QW)'(dv_r[DIV_N].quo[2]);
      sinp_r  <= dv_r[DIV_N].quo[3];
      sx_r    <= dv_r[DIV_N].x[31];
      sy_r    <= dv_r[DIV_N].y[31];
      sz_r    <= dv_r[DIV_N].z[31];
      deg_m_r <= dv_r[DIV_N].deg;
      xm_r    <= dv_r[DIV_N].x;
      ym_r    <= dv_r[DIV_N].y;
      zm_r    <= dv_r[DIV_N].z;
    end
  end

  // rounded direction components
  logic [2:0][QW-1:0] cm_r;
  logic [2:0]         cneg_r;
  logic               deg_c_r;
  logic signed [31:0] xc_r, yc_r, zc_r;
  logic [2*QW-1:0]    rcx, rcy;

  assign rcx = pcx_r + ((2*QW)'(1) << (QF - 1));
  assign rcy = pcy_r + ((2*QW)'(1) << (QF - 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      cm_r[0] <= rcx[QF+QW-1:QF];
      cm_r[1] <= rcy[QF+QW-1:QF];
      cm_r[2] <= sinp_r;
      cneg_r  <= {1'b1, sy_r ^ sz_r, sx_r ^ sz_r};
      deg_c_r <= deg_m_r;
      xc_r    <= xm_r;
      yc_r    <= ym_r;
      zc_r    <= zm_r;
    end
  end

  // displacement partial products
  logic [2:0][62:0]   lo_r;
  logic [2:0][61:0]   hi_r;
  logic [2:0]         dn_r;
  logic               deg_d_r;
  logic signed [31:0] xd_r, yd_r, zd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= 63'(dmag_r[31:0]) * 63'(cm_r[k]);
        hi_r[k] <= 62'(dmag_r[62:32]) * 62'(cm_r[k]);
        dn_r[k] <= dneg_r ^ cneg_r[k];
      end
      deg_d_r <= deg_c_r;
      xd_r    <= xc_r;
      yd_r    <= yc_r;
      zd_r    <= zc_r;
    end
  end

  // displacement magnitude
  logic [2:0][DW-1:0] dm_r;
  logic [2:0]         ds_r;
  logic               deg_s_r;
  logic signed [31:0] xs_r, ys_r, zs_r;
  logic [2:0][63:0]   hsum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hsum[k] = 64'(hi_r[k]) + 64'(lo_r[k][62:32]) + (64'(1) << (SH - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dm_r[k] <= hsum[k][63:SH];
      end
      ds_r    <= dn_r;
      deg_s_r <= deg_d_r;
      xs_r    <= xd_r;
      ys_r    <= yd_r;
      zs_r    <= zd_r;
    end
  end

  // add, clip and output register
  localparam logic signed [FW-1:0] MaxV = FW'(32'sh7fffffff);
  localparam logic signed [FW-1:0] MinV = FW'(-33'sh080000000);

  sta_pkg::out_t     out_r, out_nxt;
  logic [2:0][31:0]  pos_w;

  assign pos_w = {zs_r, ys_r, xs_r};

  always_comb begin : c_fin
    logic signed [FW-1:0] dv, sv;
    logic [2:0][31:0]     res;
    logic                 sat;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dv = ds_r[k] ? -$signed(FW'(dm_r[k])) : $signed(FW'(dm_r[k]));
      sv = FW'($signed(pos_w[k])) + dv;
      if (sv > MaxV) begin
        res[k] = 32'h7fffffff;
        sat    = 1'b1;
      end else if (sv < MinV) begin
        res[k] = 32'h80000000;
        sat    = 1'b1;
      end else begin
        res[k] = sv[31:0];
      end
    end
    if (deg_s_r) begin
      out_nxt.new_x      = xs_r;
      out_nxt.new_y      = ys_r;
      out_nxt.new_z      = zs_r;
      out_nxt.degenerate = 1'b1;
      out_nxt.saturated  = 1'b0;
    end else begin
      out_nxt.new_x      = res[0];
      out_nxt.new_y      = res[1];
      out_nxt.new_z      = res[2];
      out_nxt.degenerate = 1'b0;
      out_nxt.saturated  = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid      = vld_r[NST-1];
  assign out_ch.new_x      = out_r.new_x;
  assign out_ch.new_y      = out_r.new_y;
  assign out_ch.new_z      = out_r.new_z;
  assign out_ch.degenerate = out_r.degenerate;
  assign out_ch.saturated  = out_r.saturated;

  // some coordinate sits on a bound
  logic sat_bound;

  assign sat_bound = out_ch.new_x == 32'sh7fffffff || out_ch.new_x == 32'sh80000000 ||
                     out_ch.new_y == 32'sh7fffffff || out_ch.new_y == 32'sh80000000 ||
                     out_ch.new_z == 32'sh7fffffff || out_ch.new_z == 32'sh80000000;

  `STA_ASSERT_NEXT(a_enter, in_ch.valid && in_ch.ready, vld_r[0], "input beat lost at first stage")
  `STA_ASSERT(a_stall, !(out_ch.valid && !out_ch.ready) || !in_ch.ready, "input taken while output stalled")
  `STA_ASSERT(a_deg, !(out_ch.valid && out_ch.degenerate) || !out_ch.saturated, "degenerate beat flagged saturated")
  `STA_ASSERT(a_sat, !(out_ch.valid && out_ch.saturated) || sat_bound, "saturated beat without a bound value")

endmodule
